FILE: rtl/idm_pkg.sv
`timescale 1ns / 1ps

package idm_pkg;

  localparam int DEFAULT_WIDTH = 64;
  localparam int DATA_W        = 64;
  localparam int ACTION_W      = 2;
  localparam int IN_W          = 2 * DATA_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_UQUO = 2'd0,
    ACT_UREM = 2'd1,
    ACT_SQUO = 2'd2,
    ACT_SREM = 2'd3
  } action_t;

endpackage

FILE: rtl/int64_divide_modulo.sv
// an accepted item is loaded, then runs the restoring subtract loop in S_DIV
//   at one quotient bit per cycle, then gets its sign fix-up in S_FIX, which
//   waits for the output register to be free; no new item is taken until idle
// a zero divisor skips the loop and goes straight to S_FIX
// reset: synchronous active-high rst returns to idle and drops m_tvalid
`timescale 1ns / 1ps

module int64_divide_modulo #(
  parameter int WIDTH = idm_pkg::DEFAULT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [idm_pkg::IN_W-1:0]      s_tdata,   // dividend, divisor
  input  logic [idm_pkg::ACTION_W-1:0]  s_tuser,   // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [idm_pkg::DATA_W-1:0]    m_tdata,   // result
  output logic                          m_tuser    // divide_by_zero
);
  import idm_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIX  = 3'b100
  } state_t;

  state_t state;
  logic [CW-1:0] cnt;
  logic [WIDTH-1:0] num;
  logic [WIDTH-1:0] den;
  logic [WIDTH-1:0] rem;
  logic want_rem;
  logic neg_quo;
  logic neg_rem;
  logic zero_div;

  logic [WIDTH-1:0] in_a;
  logic [WIDTH-1:0] in_b;
  logic in_rem;
  logic in_signed;
  logic a_neg;
  logic b_neg;
  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;
  logic q_bit;
  logic [WIDTH-1:0] sel;
  logic [WIDTH-1:0] res;
  logic accept;
  logic load_out;

  assign in_a      = s_tdata[WIDTH-1:0];
  assign in_b      = s_tdata[DATA_W +: WIDTH];
  assign in_rem    = (action_t'(s_tuser) == ACT_UREM) || (action_t'(s_tuser) == ACT_SREM);
  assign in_signed = (action_t'(s_tuser) == ACT_SQUO) || (action_t'(s_tuser) == ACT_SREM);
  assign a_neg     = in_signed & in_a[WIDTH-1];
  assign b_neg     = in_signed & in_b[WIDTH-1];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load_out = (state == S_FIX) && (!m_tvalid || m_tready);

  // one restoring step
  assign trial = {rem, num[WIDTH-1]};
  assign diff  = trial - {1'b0, den};
  assign q_bit = ~diff[WIDTH];

  always_comb begin
    sel = want_rem ? rem : num;
    if (zero_div) begin
      res = want_rem ? num : {WIDTH{1'b1}};
    end else if (want_rem ? neg_rem : neg_quo) begin
      res = ~sel + WIDTH'(1);
    end else begin
      res = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt   <= CW'(WIDTH - 1);
            state <= (in_b == '0) ? S_FIX : S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      zero_div <= (in_b == '0);
      want_rem <= in_rem;
      neg_quo  <= a_neg ^ b_neg;
      neg_rem  <= a_neg;
      rem      <= '0;
      if (in_b == '0) begin
        num <= in_a;
      end else begin
        num <= a_neg ? (~in_a + WIDTH'(1)) : in_a;
      end
      den <= b_neg ? (~in_b + WIDTH'(1)) : in_b;
    end else if (state == S_DIV) begin
      num <= {num[WIDTH-2:0], q_bit};
      rem <= q_bit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    end
    if (load_out) begin
      m_tdata <= DATA_W'(res);
      m_tuser <= zero_div;
    end
  end

endmodule

FILE: rtl/idm_checker.sv
`timescale 1ns / 1ps

module idm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [idm_pkg::IN_W-1:0]      s_tdata,   // dividend, divisor
  input logic [idm_pkg::ACTION_W-1:0]  s_tuser,   // action
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [idm_pkg::DATA_W-1:0]    m_tdata,   // result
  input logic                          m_tuser    // divide_by_zero
);
  import idm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // busy right after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // no result appears in the cycle after an item is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result too early");

  // reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

endmodule

bind int64_divide_modulo idm_checker u_idm_checker (.*);
